>>> rtl/lgs_pkg.sv
// Shared types, constants and helpers for the life generation step block.
// Holds the job record passed from the front part to the back part.
// No dependencies.
package lgs_pkg;

  localparam int COLS = 64;
  localparam int CFG_W = 7;
  localparam int CNT_W = 7;
  localparam int STAT_W = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(COLS);
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;
  localparam logic [STAT_W-1:0] STAT_MAX = '1;

  // One queued job: the three-row window of the first result, whether that
  // result closes the frame, and whether a second, closing result follows.
  typedef struct packed {
    logic [COLS-1:0] up;
    logic [COLS-1:0] mid;
    logic [COLS-1:0] down;
    logic            first_last;
    logic            pair;
  } lgs_job_t;

  // Mask of the columns in use; widths above the grid act as the grid width.
  function automatic logic [COLS-1:0] width_mask(input logic [CFG_W-1:0] cols);
    logic [CFG_W-1:0] n;
    n = (cols > CFG_W'(COLS)) ? CFG_W'(COLS) : cols;
    if (n >= CFG_W'(COLS)) begin
      width_mask = '1;
    end else begin
      width_mask = (COLS'(1) << n) - COLS'(1);
    end
  endfunction

endpackage

>>> rtl/lgs_front.sv
// Front part of the life generation step: takes rows and forms jobs.
// Keeps the row above and the row in hand; depends on lgs_pkg.
module lgs_front
  import lgs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [COLS-1:0] col_mask,
  input  logic            take,
  input  logic [COLS-1:0] row_cells,
  input  logic            last_row,
  output logic            push,
  output lgs_job_t        job
);

  logic [COLS-1:0] row_above_r, row_above_nxt;
  logic [COLS-1:0] row_middle_r, row_middle_nxt;
  logic            middle_valid_r, middle_valid_nxt;
  logic [COLS-1:0] row;

  assign row = row_cells & col_mask;

  always_comb begin
    row_above_nxt = row_above_r;
    row_middle_nxt = row_middle_r;
    middle_valid_nxt = middle_valid_r;
    push = 1'b0;
    job.up = row_above_r;
    job.mid = row_middle_r;
    job.down = row;
    job.first_last = 1'b0;
    job.pair = last_row;
    if (take) begin
      if (!middle_valid_r) begin
        // A lone row marked last is a whole grid on its own.
        job.up = '0;
        job.mid = row;
        job.down = '0;
        job.first_last = 1'b1;
        job.pair = 1'b0;
        push = last_row;
        row_above_nxt = '0;
        row_middle_nxt = row;
        middle_valid_nxt = !last_row;
      end else begin
        push = 1'b1;
        if (last_row) begin
          row_above_nxt = '0;
          middle_valid_nxt = 1'b0;
        end else begin
          row_above_nxt = row_middle_r;
          row_middle_nxt = row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_above_r <= '0;
      middle_valid_r <= 1'b0;
    end else begin
      row_above_r <= row_above_nxt;
      middle_valid_r <= middle_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_middle_r <= row_middle_nxt;
  end

endmodule

>>> rtl/lgs_queue.sv
// Short job queue between the front and back parts of the life step.
// Flip-flop storage, one push and one pop a cycle; depends on lgs_pkg.
module lgs_queue
  import lgs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lgs_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output lgs_job_t head
);

  lgs_job_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;
  logic                do_pop;

  assign full = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head = slot_r[rd_ptr_r];
  assign do_pop = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> rtl/lgs_back.sv
// Back part of the life step: evaluates jobs, counts changes, keeps totals.
// Two register stages, the second being the output register; uses lgs_pkg.
module lgs_back
  import lgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [COLS-1:0]   col_mask,
  input  logic              job_valid,
  input  lgs_job_t          job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COLS-1:0]   out_new_row,
  output logic [CNT_W-1:0]  out_row_births,
  output logic [CNT_W-1:0]  out_row_deaths,
  output logic              out_last_of_frame,
  output logic [STAT_W-1:0] out_frame_births,
  output logic [STAT_W-1:0] out_frame_deaths,
  output logic [STAT_W-1:0] out_stable_generations
);

  // Next state of every cell of mid, all columns side by side.
  function automatic logic [COLS-1:0] next_gen(input logic [COLS-1:0] up,
                                               input logic [COLS-1:0] mid,
                                               input logic [COLS-1:0] down);
    logic [COLS+1:0] u;
    logic [COLS+1:0] m;
    logic [COLS+1:0] d;
    logic [3:0]      cnt;
    logic [COLS-1:0] res;
    u = {1'b0, up, 1'b0};
    m = {1'b0, mid, 1'b0};
    d = {1'b0, down, 1'b0};
    for (int c = 0; c < COLS; c++) begin
      cnt = 4'(u[c]) + 4'(u[c+1]) + 4'(u[c+2]) + 4'(m[c]) + 4'(m[c+2])
          + 4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
      res[c] = (cnt == BIRTH_COUNT) || (m[c+1] && (cnt == SURVIVE_COUNT));
    end
    return res;
  endfunction

  logic              second_r, second_nxt;
  logic              s1_valid_r;
  logic [COLS-1:0]   s1_row_r, s1_born_r, s1_died_r;
  logic              s1_last_r;
  logic              s1_load, s1_move, s2_load;

  logic [COLS-1:0]   win_up, win_mid, win_down, nxt_row;
  logic              win_last;

  logic [STAT_W-1:0] births_total_r, births_total_nxt;
  logic [STAT_W-1:0] deaths_total_r, deaths_total_nxt;
  logic [STAT_W-1:0] stable_count_r, stable_count_nxt;
  logic [CNT_W-1:0]  born_cnt, died_cnt;
  logic [STAT_W:0]   b_sum, d_sum;
  logic [STAT_W-1:0] b_sat, d_sat, stable_out;

  assign s2_load = !out_valid || !out_stall;
  assign s1_move = s1_valid_r && s2_load;
  assign s1_load = job_valid && (!s1_valid_r || s1_move);

  // The second beat of a pair shifts the window down one row.
  always_comb begin
    if (second_r) begin
      win_up = job.mid;
      win_mid = job.down;
      win_down = '0;
      win_last = 1'b1;
    end else begin
      win_up = job.up;
      win_mid = job.mid;
      win_down = job.down;
      win_last = job.first_last;
    end
    win_up = win_up & col_mask;
    win_mid = win_mid & col_mask;
    win_down = win_down & col_mask;
    nxt_row = next_gen(win_up, win_mid, win_down) & col_mask;
  end

  always_comb begin
    second_nxt = second_r;
    job_pop = 1'b0;
    if (s1_load) begin
      if (job.pair && !second_r) begin
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        job_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_row_r <= nxt_row;
      s1_born_r <= nxt_row & ~win_mid;
      s1_died_r <= win_mid & ~nxt_row;
      s1_last_r <= win_last;
    end
  end

  // Counting and frame totals, done as a row enters the output register.
  always_comb begin
    born_cnt = CNT_W'($countones(s1_born_r));
    died_cnt = CNT_W'($countones(s1_died_r));
    b_sum = {1'b0, births_total_r} + (STAT_W+1)'(born_cnt);
    d_sum = {1'b0, deaths_total_r} + (STAT_W+1)'(died_cnt);
    b_sat = b_sum[STAT_W] ? STAT_MAX : b_sum[STAT_W-1:0];
    d_sat = d_sum[STAT_W] ? STAT_MAX : d_sum[STAT_W-1:0];
    births_total_nxt = births_total_r;
    deaths_total_nxt = deaths_total_r;
    stable_count_nxt = stable_count_r;
    if (s1_move) begin
      if (s1_last_r) begin
        births_total_nxt = '0;
        deaths_total_nxt = '0;
        if (b_sat == d_sat) begin
          if (stable_count_r != STAT_MAX) begin
            stable_count_nxt = stable_count_r + STAT_W'(1);
          end
        end else begin
          stable_count_nxt = '0;
        end
      end else begin
        births_total_nxt = b_sat;
        deaths_total_nxt = d_sat;
      end
    end
    stable_out = s1_last_r ? stable_count_nxt : stable_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      births_total_r <= '0;
      deaths_total_r <= '0;
      stable_count_r <= '0;
      out_valid <= 1'b0;
    end else begin
      births_total_r <= births_total_nxt;
      deaths_total_r <= deaths_total_nxt;
      stable_count_r <= stable_count_nxt;
      if (s2_load) begin
        out_valid <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_new_row <= s1_row_r;
      out_row_births <= born_cnt;
      out_row_deaths <= died_cnt;
      out_last_of_frame <= s1_last_r;
      out_frame_births <= s1_last_r ? b_sat : '0;
      out_frame_deaths <= s1_last_r ? d_sat : '0;
      out_stable_generations <= stable_out;
    end
  end

endmodule

>>> rtl/life_generation_step.sv
// Top level of the life generation step: one B3/S23 generation, row by row.
// Instantiates lgs_front, lgs_queue and lgs_back; uses lgs_pkg.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_row_cells, in_last_row
//   out_     output     out_valid/out_stall new row, change counts, frame stats
//   cfg_     input      cfg_valid/cfg_ready cfg_cols_in_use
//
// One row is taken each cycle while the four-entry job queue has room.
// A row marked last that closes a taller grid yields two results, so the back
// part evaluates that job twice; other rows yield at most one result. A result
// passes the queue, the stage-one register and the output register after the row
// below it (or a lone last row) is taken; the closing result of a pair follows
// the first. Reset (rst_n low at a clock edge) drops the held rows, clears the
// totals and the stable count, and sets the width to 64 columns. A stalled
// output holds both back stages; the queue then fills and in_stall rises.
module life_generation_step
  import lgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [COLS-1:0]   in_row_cells,
  input  logic              in_last_row,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COLS-1:0]   out_new_row,
  output logic [CNT_W-1:0]  out_row_births,
  output logic [CNT_W-1:0]  out_row_deaths,
  output logic              out_last_of_frame,
  output logic [STAT_W-1:0] out_frame_births,
  output logic [STAT_W-1:0] out_frame_deaths,
  output logic [STAT_W-1:0] out_stable_generations,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_cols_in_use
);

  logic [CFG_W-1:0] cols_r;
  logic [COLS-1:0]  col_mask;
  logic             take, push, pop, full, not_empty;
  lgs_job_t         new_job, head_job;

  assign cfg_ready = 1'b1;
  assign col_mask = width_mask(cols_r);
  assign in_stall = full;
  assign take = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cols_r <= cfg_cols_in_use;
    end
  end

  lgs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_mask  (col_mask),
    .take      (take),
    .row_cells (in_row_cells),
    .last_row  (in_last_row),
    .push      (push),
    .job       (new_job)
  );

  lgs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (new_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head_job)
  );

  lgs_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .col_mask               (col_mask),
    .job_valid              (not_empty),
    .job                    (head_job),
    .job_pop                (pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_new_row            (out_new_row),
    .out_row_births         (out_row_births),
    .out_row_deaths         (out_row_deaths),
    .out_last_of_frame      (out_last_of_frame),
    .out_frame_births       (out_frame_births),
    .out_frame_deaths       (out_frame_deaths),
    .out_stable_generations (out_stable_generations)
  );

endmodule
